[src/tna_pkg.sv]
// ----------------------------------------------------------------------------
// tna_pkg: shared types for the triangle normal and area block
// Word layouts of the vertex channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

package tna_pkg;

  localparam int COORD_W = 16;
  localparam int NORM_W  = 16;
  localparam int AREA_W  = 34;

  typedef struct packed {
    logic [COORD_W-1:0] a_x;
    logic [COORD_W-1:0] a_y;
    logic [COORD_W-1:0] a_z;
    logic [COORD_W-1:0] b_x;
    logic [COORD_W-1:0] b_y;
    logic [COORD_W-1:0] b_z;
    logic [COORD_W-1:0] c_x;
    logic [COORD_W-1:0] c_y;
    logic [COORD_W-1:0] c_z;
  } vert_word_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [AREA_W-1:0]        twice_area;
    logic                     degenerate;
  } res_word_t;

endpackage

`default_nettype wire

[src/tna_stage.sv]
// ----------------------------------------------------------------------------
// tna_stage: one step of the normalization pipeline
// Per lane, one restoring-division step or one root digit of the quotient, and
// in the first AB steps one root digit of the squared magnitude; registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tna_stage #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 15,
  parameter int STEP       = 0
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [2*(2*COORD_BITS+1)+1:0]       prev_s,
  input  wire logic                                prev_degen,
  input  wire logic [2:0]                          prev_neg,
  input  wire logic [2*COORD_BITS+3:0]             prev_arem,
  input  wire logic [2*COORD_BITS+1:0]             prev_root,
  input  wire logic [2:0][2*(2*COORD_BITS+1)+1:0]  prev_drem,
  input  wire logic [2:0][2*FRAC_BITS+2:0]         prev_q,
  input  wire logic [2:0][FRAC_BITS+3:0]           prev_mrem,
  input  wire logic [2:0][FRAC_BITS+1:0]           prev_mroot,
  output logic [2*(2*COORD_BITS+1)+1:0]            s,
  output logic                                     degen,
  output logic [2:0]                               neg,
  output logic [2*COORD_BITS+3:0]                  arem,
  output logic [2*COORD_BITS+1:0]                  root,
  output logic [2:0][2*(2*COORD_BITS+1)+1:0]       drem,
  output logic [2:0][2*FRAC_BITS+2:0]              q,
  output logic [2:0][FRAC_BITS+3:0]                mrem,
  output logic [2:0][FRAC_BITS+1:0]                mroot
);

  localparam int NB = 2*COORD_BITS + 1;
  localparam int SB = 2*NB + 2;
  localparam int AB = SB / 2;
  localparam int AW = AB + 2;
  localparam int QB = 2*FRAC_BITS + 3;
  localparam int MB = FRAC_BITS + 2;
  localparam int MR = FRAC_BITS + 4;

  logic [AW-1:0]           arem_next;
  logic [AB-1:0]           root_next;
  logic [2:0][SB-1:0]      drem_next;
  logic [2:0][QB-1:0]      q_next;
  logic [2:0][MR-1:0]      mrem_next;
  logic [2:0][MB-1:0]      mroot_next;

  // Root of the squared magnitude, two bits of it per step.
  if (STEP < AB) begin : g_area
    logic [AB+3:0] rf;
    logic [AB+3:0] tr;
    logic          take;
    assign rf        = {prev_arem, prev_s[SB-1-2*STEP -: 2]};
    assign tr        = {2'b00, prev_root, 2'b01};
    assign take      = rf >= tr;
    assign arem_next = take ? AW'(rf - tr) : rf[AW-1:0];
    assign root_next = {prev_root[AB-2:0], take};
  end else begin : g_area_hold
    assign arem_next = prev_arem;
    assign root_next = prev_root;
  end

  if (STEP < QB) begin : g_div
    // The first step takes the square unshifted: it already holds the lowest
    // numerator bit, and all numerator bits below it are zero.
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [SB:0] rf;
      logic [SB:0] dv;
      logic        take;
      assign rf           = (STEP == 0) ? {1'b0, prev_drem[l]} : {prev_drem[l], 1'b0};
      assign dv           = {1'b0, prev_s};
      assign take         = rf >= dv;
      assign drem_next[l] = take ? SB'(rf - dv) : rf[SB-1:0];
      assign q_next[l]    = {prev_q[l][QB-2:0], take};
    end
    assign mrem_next  = prev_mrem;
    assign mroot_next = prev_mroot;
  end else if (STEP < QB + MB) begin : g_sqrt
    localparam int K = STEP - QB;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [QB:0]   qp;
      logic [MR+1:0] rf;
      logic [MR+1:0] tr;
      logic          take;
      assign qp            = {1'b0, prev_q[l]};
      assign rf            = {prev_mrem[l], qp[QB-2*K -: 2]};
      assign tr            = {2'b00, prev_mroot[l], 2'b01};
      assign take          = rf >= tr;
      assign mrem_next[l]  = take ? MR'(rf - tr) : rf[MR-1:0];
      assign mroot_next[l] = {prev_mroot[l][MB-2:0], take};
    end
    assign drem_next = prev_drem;
    assign q_next    = prev_q;
  end else begin : g_hold
    assign drem_next  = prev_drem;
    assign q_next     = prev_q;
    assign mrem_next  = prev_mrem;
    assign mroot_next = prev_mroot;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s     <= prev_s;
      degen <= prev_degen;
      neg   <= prev_neg;
      arem  <= arem_next;
      root  <= root_next;
      drem  <= drem_next;
      q     <= q_next;
      mrem  <= mrem_next;
      mroot <= mroot_next;
    end
  end

endmodule

`default_nettype wire

[src/triangle_normal_area_top.sv]
// ----------------------------------------------------------------------------
// triangle_normal_area_top: unit normal and doubled area of a triangle
// Cross product of the edges from vertex a, exact squared magnitude, then per-component
// division and square roots to give a Q1.FRAC_BITS normal and floor(|N|).
// ----------------------------------------------------------------------------
// Usage:
// The vert channel carries one triangle (three vertices) per word; the res
// channel returns one word per triangle, in order. A word moves at a clock
// edge where valid is high and stall is low.
// Throughput is one word per cycle while res_stall is low: four stages form
// the edges, products, cross product and squares, one stage sums the squared
// magnitude, then 2*FRAC_BITS+3 restoring-division steps and FRAC_BITS+2 root
// digit steps run one per stage (the area root runs alongside), and a final
// stage rounds, saturates and registers the result word.
// Every stage has its own valid bit and advances when the stage ahead is
// empty or moving, so bubbles close up and new words are taken while a
// result waits on a stalled receiver. vert_stall rises only when every stage
// holds a word. A degenerate triangle gives a zero normal and zero area.
// Reset (synchronous, rst high) empties the pipeline; no result is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_normal_area_top import tna_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       vert_valid,
  output logic            vert_stall,
  input  wire vert_word_t vert,
  output logic            res_valid,
  input  wire logic       res_stall,
  output res_word_t       res
);

  localparam int CB   = COORD_BITS;
  localparam int D    = CB + 1;
  localparam int PW   = 2*D;
  localparam int NB   = 2*CB + 1;
  localparam int SB   = 2*NB + 2;
  localparam int AB   = SB / 2;
  localparam int QB   = 2*FRAC_BITS + 3;
  localparam int MB   = FRAC_BITS + 2;
  localparam int MR   = FRAC_BITS + 4;
  localparam int ITER = (QB + MB > AB) ? QB + MB : AB;
  localparam int NST  = ITER + 6;
  localparam int LIM  = (1 << FRAC_BITS) - 1;

  logic [NST-1:0] vld;
  logic [NST-1:0] vld_in;
  logic [NST:0]   rdy;

  assign rdy[NST] = !res_stall;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end
  assign vld_in     = {vld[NST-2:0], vert_valid};
  assign vert_stall = !rdy[0];
  assign res_valid  = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // Edge vectors from the first vertex.
  logic signed [D-1:0] eu [3];
  logic signed [D-1:0] ev [3];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      eu[0] <= $signed({1'b0, vert.b_x[CB-1:0]}) - $signed({1'b0, vert.a_x[CB-1:0]});
      eu[1] <= $signed({1'b0, vert.b_y[CB-1:0]}) - $signed({1'b0, vert.a_y[CB-1:0]});
      eu[2] <= $signed({1'b0, vert.b_z[CB-1:0]}) - $signed({1'b0, vert.a_z[CB-1:0]});
      ev[0] <= $signed({1'b0, vert.c_x[CB-1:0]}) - $signed({1'b0, vert.a_x[CB-1:0]});
      ev[1] <= $signed({1'b0, vert.c_y[CB-1:0]}) - $signed({1'b0, vert.a_y[CB-1:0]});
      ev[2] <= $signed({1'b0, vert.c_z[CB-1:0]}) - $signed({1'b0, vert.a_z[CB-1:0]});
    end
  end

  logic signed [PW-1:0] pr [6];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pr[0] <= eu[1] * ev[2];
      pr[1] <= eu[2] * ev[1];
      pr[2] <= eu[2] * ev[0];
      pr[3] <= eu[0] * ev[2];
      pr[4] <= eu[0] * ev[1];
      pr[5] <= eu[1] * ev[0];
    end
  end

  // Cross product; each component stays below 2^(2*CB+1) in magnitude.
  logic signed [PW-1:0] nc   [3];
  logic        [PW-1:0] nabs [3];
  logic        [2:0]    nneg;
  logic        [NB-1:0] nmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nc[i]   = pr[2*i] - pr[2*i+1];
      nabs[i] = nc[i][PW-1] ? PW'(-nc[i]) : PW'(nc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        nneg[i] <= nc[i][PW-1];
        nmag[i] <= nabs[i][NB-1:0];
      end
    end
  end

  logic [2*NB-1:0] sq [3];
  logic [2:0]      sneg;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sneg <= nneg;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= nmag[i] * nmag[i];
      end
    end
  end

  // Pipeline records of the iterative section; entry 0 is the sum stage.
  logic [SB-1:0]      r_s     [ITER+1];
  logic               r_degen [ITER+1];
  logic [2:0]         r_neg   [ITER+1];
  logic [AB+1:0]      r_arem  [ITER+1];
  logic [AB-1:0]      r_root  [ITER+1];
  logic [2:0][SB-1:0] r_drem  [ITER+1];
  logic [2:0][QB-1:0] r_q     [ITER+1];
  logic [2:0][MR-1:0] r_mrem  [ITER+1];
  logic [2:0][MB-1:0] r_mroot [ITER+1];

  logic [SB-1:0] ssum;
  assign ssum = SB'(sq[0]) + SB'(sq[1]) + SB'(sq[2]);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      r_s[0]     <= ssum;
      r_degen[0] <= ssum == '0;
      r_neg[0]   <= sneg;
      r_arem[0]  <= '0;
      r_root[0]  <= '0;
      r_q[0]     <= '0;
      r_mrem[0]  <= '0;
      r_mroot[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        r_drem[0][i] <= SB'(sq[i]);
      end
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_step
    tna_stage #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .STEP       (k - 1)
    ) u_stage (
      .clk        (clk),
      .en         (rdy[4+k]),
      .prev_s     (r_s[k-1]),
      .prev_degen (r_degen[k-1]),
      .prev_neg   (r_neg[k-1]),
      .prev_arem  (r_arem[k-1]),
      .prev_root  (r_root[k-1]),
      .prev_drem  (r_drem[k-1]),
      .prev_q     (r_q[k-1]),
      .prev_mrem  (r_mrem[k-1]),
      .prev_mroot (r_mroot[k-1]),
      .s          (r_s[k]),
      .degen      (r_degen[k]),
      .neg        (r_neg[k]),
      .arem       (r_arem[k]),
      .root       (r_root[k]),
      .drem       (r_drem[k]),
      .q          (r_q[k]),
      .mrem       (r_mrem[k]),
      .mroot      (r_mroot[k])
    );
  end

  // Round half up on the doubled-precision root, then saturate and sign.
  res_word_t         res_next;
  logic [NORM_W-1:0] nrm [3];

  always_comb begin
    logic [MB:0]       kr;
    logic [MB-1:0]     kv;
    logic [NORM_W-1:0] kn;
    for (int i = 0; i < 3; i++) begin
      kr = {1'b0, r_mroot[ITER][i]} + (MB+1)'(1);
      kv = kr[MB:1];
      if (kv > MB'(LIM)) begin
        kv = MB'(LIM);
      end
      kn = NORM_W'(kv);
      nrm[i] = r_neg[ITER][i] ? NORM_W'(-kn) : kn;
      if (r_degen[ITER]) begin
        nrm[i] = '0;
      end
    end
    res_next.norm_x     = nrm[0];
    res_next.norm_y     = nrm[1];
    res_next.norm_z     = nrm[2];
    res_next.twice_area = r_degen[ITER] ? '0 : AREA_W'(r_root[ITER]);
    res_next.degenerate = r_degen[ITER];
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[src/tna_chk.sv]
// ----------------------------------------------------------------------------
// tna_chk: port checker for the triangle normal and area block
// Watches the result channel over time and binds to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tna_chk import tna_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       vert_valid,
  input wire logic       vert_stall,
  input wire vert_word_t vert,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire res_word_t  res
);

  // A stalled result word holds until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // A degenerate triangle has a zero normal and zero area.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.degenerate |->
      res.norm_x == '0 && res.norm_y == '0 && res.norm_z == '0 &&
      res.twice_area == '0)
    else $error("degenerate result not zero");

  // Any other triangle has a nonzero area and a nonzero normal.
  a_live_area: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.degenerate |->
      res.twice_area != '0 &&
      (res.norm_x != '0 || res.norm_y != '0 || res.norm_z != '0))
    else $error("nondegenerate result with zero area or normal");

endmodule

bind triangle_normal_area_top tna_chk u_tna_chk (
  .clk        (clk),
  .rst        (rst),
  .vert_valid (vert_valid),
  .vert_stall (vert_stall),
  .vert       (vert),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res        (res)
);

`default_nettype wire

[sim/tna_checker.sv]
// ----------------------------------------------------------------------------
// tna_checker: result predictor and scoreboard for the triangle normal block
// Watches both channels, computes the expected normal and doubled area of
// every accepted triangle, and compares each result word in order.
// ----------------------------------------------------------------------------
module tna_checker import tna_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       vert_valid,
  input  logic       vert_stall,
  input  vert_word_t vert,
  input  logic       res_valid,
  input  logic       res_stall,
  input  res_word_t  res,
  output int         fail_count,
  output int         pending
);

  localparam int FRAC = 15;

  res_word_t expected_q[$];

  // floor(sqrt(s)) for s below 2^70.
  function automatic longint unsigned isqrt70(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r[63:0];
  endfunction

  function automatic logic [15:0] unit_comp(longint c, logic [127:0] s);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] m;
    logic [127:0] t;
    logic [127:0] k;
    mag = (c < 0) ? -c : c;
    q = ((mag * mag) << (2 * FRAC + 2)) / s;
    q = q[63:0];
    m = 0;
    for (int b = FRAC + 1; b >= 0; b--) begin
      t = m | (128'd1 << b);
      if (t * t <= q) m = t;
    end
    k = (m + 1) >> 1;
    if (k > (1 << FRAC) - 1) k = (1 << FRAC) - 1;
    if (c < 0) k = -k;
    return k[15:0];
  endfunction

  function automatic res_word_t predict_normal(vert_word_t w);
    res_word_t r;
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic signed [127:0] wx, wy, wz;
    logic [127:0] s;
    ux = longint'(w.b_x) - longint'(w.a_x);
    uy = longint'(w.b_y) - longint'(w.a_y);
    uz = longint'(w.b_z) - longint'(w.a_z);
    vx = longint'(w.c_x) - longint'(w.a_x);
    vy = longint'(w.c_y) - longint'(w.a_y);
    vz = longint'(w.c_z) - longint'(w.a_z);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    // Squares reach 66 bits, so they are formed at full width.
    wx = nx;
    wy = ny;
    wz = nz;
    s = wx * wx + wy * wy + wz * wz;
    r = '0;
    if (s == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.norm_x = unit_comp(nx, s);
      r.norm_y = unit_comp(ny, s);
      r.norm_z = unit_comp(nz, s);
      r.twice_area = AREA_W'(isqrt70(s));
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    res_word_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (vert_valid && !vert_stall) expected_q.push_back(predict_normal(vert));
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", res);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (res.norm_x !== e.norm_x || res.norm_y !== e.norm_y ||
              res.norm_z !== e.norm_z || res.twice_area !== e.twice_area ||
              res.degenerate !== e.degenerate) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", e, res);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[sim/tb_triangle_normal_area_top.sv]
// ----------------------------------------------------------------------------
// tb_triangle_normal_area_top: testbench for the triangle normal block
// Drives directed and random triangles with random gaps and receiver stalls,
// including one long hold-off; the checker compares every result word.
// ----------------------------------------------------------------------------
module tb_triangle_normal_area_top;
  import tna_pkg::*;

  logic       clk;
  logic       rst;
  logic       vert_valid;
  logic       vert_stall;
  vert_word_t vert;
  logic       res_valid;
  logic       res_stall;
  res_word_t  res;
  int         fail_count;
  int         pending;
  logic       quiet_mode;
  int         idle_cycles;

  triangle_normal_area_top DUT (
    .clk(clk), .rst(rst), .vert_valid(vert_valid), .vert_stall(vert_stall),
    .vert(vert), .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  tna_checker u_checker (
    .clk(clk), .rst(rst), .vert_valid(vert_valid), .vert_stall(vert_stall),
    .vert(vert), .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      3: return 16'($urandom_range(65520, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vert_word_t random_triangle();
    vert_word_t w;
    w.a_x = rand_coord(); w.a_y = rand_coord(); w.a_z = rand_coord();
    w.b_x = rand_coord(); w.b_y = rand_coord(); w.b_z = rand_coord();
    w.c_x = rand_coord(); w.c_y = rand_coord(); w.c_z = rand_coord();
    // Now and then make the triangle collinear or collapsed.
    if ($urandom_range(0, 19) == 0) begin
      w.c_x = w.b_x; w.c_y = w.b_y; w.c_z = w.b_z;
    end else if ($urandom_range(0, 19) == 0) begin
      w.b_x = w.a_x; w.b_y = w.a_y; w.b_z = w.a_z;
    end
    return w;
  endfunction

  function automatic vert_word_t tri_of(logic [15:0] ax, ay, az, bx, by, bz,
                                        cx, cy, cz);
    vert_word_t w;
    w = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return w;
  endfunction

  vert_word_t directed_q[$];

  task automatic send_word(vert_word_t w);
    if (!quiet_mode) begin
      while ($urandom_range(0, 99) < 13) begin
        vert_valid <= 1'b0;
        @(posedge clk);
      end
    end
    vert_valid <= 1'b1;
    vert <= w;
    @(posedge clk);
    while (vert_stall) @(posedge clk);
  endtask

  // Receiver: random stalls, one quiet stretch, one long hold-off.
  initial begin
    int n;
    res_stall = 1'b0;
    n = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      n++;
      if (n >= 400 && n < 700) res_stall <= 1'b1;
      else if (quiet_mode) res_stall <= 1'b0;
      else res_stall <= ($urandom_range(0, 99) < 13);
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if (rst || (vert_valid && !vert_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int wait_n;
    rst = 1'b1;
    vert_valid = 1'b0;
    vert = '0;
    quiet_mode = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_q.push_back(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(tri_of('1, '1, '1, '1, '1, '1, '1, '1, '1));
    directed_q.push_back(tri_of(0, 0, 0, '1, 0, 0, 0, '1, 0));
    directed_q.push_back(tri_of(0, 0, 0, 0, '1, 0, 0, 0, '1));
    directed_q.push_back(tri_of(0, 0, 0, 0, 0, '1, '1, 0, 0));
    directed_q.push_back(tri_of(0, 0, 0, 0, '1, 0, '1, 0, 0));
    directed_q.push_back(tri_of('1, '1, '1, 0, '1, '1, '1, 0, '1));
    directed_q.push_back(tri_of(0, 0, 0, '1, 0, 0, 0, '1, '1));
    directed_q.push_back(tri_of(0, 0, '1, '1, 0, '1, 0, '1, 0));
    directed_q.push_back(tri_of(1, 2, 3, 2, 4, 6, 3, 6, 9));
    directed_q.push_back(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_q.push_back(tri_of(5, 5, 5, 6, 5, 5, 5, 6, 6));
    directed_q.push_back(tri_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 16'h0F0F));
    directed_q.push_back(tri_of('1, 0, '1, 0, '1, 0, '1, '1, 0));
    foreach (directed_q[i]) send_word(directed_q[i]);

    for (int i = 0; i < 2000; i++) begin
      quiet_mode = (i >= 600 && i < 900);
      send_word(random_triangle());
    end
    quiet_mode = 1'b0;
    vert_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    wait_n = 0;
    while (wait_n < 80) begin
      @(posedge clk);
      wait_n++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
